>>> hdl/mfde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_pkg
// shared types and constants of the framebuffer draw engine
// ----------------------------------------------------------------------------
package mfde_pkg;

	localparam int COLUMNS_DEF = 128;
	localparam int PAGES_DEF   = 8;
	localparam int COORD_W     = 8;

	typedef enum logic [2:0] {
		OP_SET   = 3'd0,
		OP_CLR   = 3'd1,
		OP_FILL  = 3'd2,
		OP_ERASE = 3'd3,
		OP_LINE  = 3'd4,
		OP_RECT  = 3'd5,
		OP_WIPE  = 3'd6,
		OP_READ  = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_AREA,
		ST_LSETUP,
		ST_LINE,
		ST_RD,
		ST_WAIT,
		ST_WB,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

>>> hdl/mono_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// line, rectangle, point and area drawing, clearing and byte reads on a one-bit page framebuffer
// ----------------------------------------------------------------------------
// each pixel is a read-modify-write of one store byte; a rectangle is drawn
// as four lines, and clear all zeroes every store byte
// one command at a time; one result item per command
// after reset a clearing pass zeroes all PAGES*COLUMNS bytes before the first command is taken
module mono_framebuffer_draw_engine
	import mfde_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int PAGES   = PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // op, start_x, start_y, end_x, end_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data, done_op
);
	localparam int DEPTH = PAGES * COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROWS  = PAGES * 8;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	state_t state_q, state_nx;
	op_t    op_q;
	logic   boot_q;
	logic [7:0] xa_q, ya_q, xb_q, yb_q;
	logic [AW:0] sweep_q;
	logic [7:0] ax_q, ay_q;
	// line walker
	logic [8:0] cx_q, cy_q;   // signed via carry of 9 bits not needed: stays in 0..255
	logic [7:0] ldx_q, ldy_q, dist_q;
	logic [8:0] ex_q, ey_q;
	logic       sxn_q, syn_q;
	logic [8:0] t_q;
	logic [1:0] seg_q;
	logic       area_mode_q, pix_on_q;
	logic [7:0] px_q, py_q;
	logic [7:0] rd_out_q;
	logic [7:0] l1x, l1y, l2x, l2y;

	// pixel address
	logic        px_ok;
	logic [AW-1:0] px_addr;
	logic [15:0] px_full;
	assign px_ok   = ({8'd0, px_q} < 16'(COLUMNS)) && ({8'd0, py_q} < 16'(ROWS));
	assign px_full = 16'(py_q >> 3) * 16'(COLUMNS) + 16'(px_q);
	assign px_addr = px_full[AW-1:0];

	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_full;
	assign rd_full = 16'(ya_q) * 16'(COLUMNS) + 16'(xa_q);
	assign rd_addr = rd_full[AW-1:0];
	logic rd_ok;
	assign rd_ok = ({8'd0, xa_q} < 16'(COLUMNS)) && ({8'd0, ya_q} < 16'(PAGES));

	logic       mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0] mem_wd;
	logic [7:0] bitm;
	assign bitm = 8'd1 << py_q[2:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = px_addr;
		mem_wd = pix_on_q ? (rdata_q | bitm) : (rdata_q & ~bitm);
		mem_ra = (op_q == OP_READ) ? rd_addr : px_addr;
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
			mem_wa = sweep_q[AW-1:0];
			mem_wd = 8'd0;
		end else if (state_q == ST_WB) begin
			mem_we = px_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	// segment endpoints for the line walker
	always_comb begin
		l1x = xa_q; l1y = ya_q; l2x = xb_q; l2y = yb_q;
		if (op_q == OP_RECT) begin
			unique case (seg_q)
				2'd0: begin l2y = ya_q; end
				2'd1: begin l2x = xa_q; end
				2'd2: begin l1y = yb_q; end
				default: begin l1x = xb_q; end
			endcase
		end
	end

	logic [8:0] ex_n, ey_n;
	assign ex_n = ex_q + {1'b0, ldx_q};
	assign ey_n = ey_q + {1'b0, ldy_q};
	logic last_pt, sweep_end;
	assign last_pt   = (t_q == {1'b0, dist_q} + 9'd1);
	assign sweep_end = (sweep_q == (AW+1)'(DEPTH - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) begin
				unique case (op_t'(s_tdata[2:0]))
					OP_SET, OP_CLR: state_nx = ST_RD;
					OP_FILL, OP_ERASE: state_nx = ST_AREA;
					OP_LINE, OP_RECT: state_nx = ST_LSETUP;
					OP_WIPE: state_nx = ST_SWEEP;
					default: state_nx = ST_RD;
				endcase
			end
			ST_SWEEP: if (sweep_end) state_nx = boot_q ? ST_IDLE : ST_RESP;
			ST_AREA: state_nx = ((xa_q < xb_q) && (ya_q < yb_q)) ? ST_RD : ST_RESP;
			ST_LSETUP: state_nx = ST_RD;
			ST_RD: state_nx = (op_q == OP_READ) ? ST_DRAIN : ST_WAIT;
			ST_WAIT: state_nx = ST_WB;
			ST_WB: begin
				if (area_mode_q) begin
					if ((ay_q + 8'd1 == yb_q) && (ax_q + 8'd1 == xb_q)) state_nx = ST_RESP;
					else state_nx = ST_RD;
				end else if (op_q == OP_LINE || op_q == OP_RECT) begin
					if (last_pt && (op_q == OP_LINE || seg_q == 2'd3)) state_nx = ST_RESP;
					else if (last_pt) state_nx = ST_LSETUP;
					else state_nx = ST_RD;
				end else state_nx = ST_RESP;
			end
			ST_DRAIN: state_nx = ST_RESP;
			ST_RESP: if (m_tready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_RESP);
		m_tdata  = {5'd0, op_q, rd_out_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			op_q    <= OP_WIPE;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SWEEP) sweep_q <= sweep_q + 1'b1;
			if (state_q == ST_SWEEP && sweep_end) boot_q <= 1'b0;
			if (state_q == ST_IDLE && s_tvalid) begin
				op_q    <= op_t'(s_tdata[2:0]);
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				xa_q <= s_tdata[10:3];  ya_q <= s_tdata[18:11];
				xb_q <= s_tdata[26:19]; yb_q <= s_tdata[34:27];
				px_q <= s_tdata[10:3];  py_q <= s_tdata[18:11];
				pix_on_q <= (s_tdata[2:0] != OP_CLR) && (s_tdata[2:0] != OP_ERASE);
				area_mode_q <= (s_tdata[2:0] == OP_FILL) || (s_tdata[2:0] == OP_ERASE);
				seg_q <= 2'd0;
				rd_out_q <= 8'd0;
			end
			ST_AREA: begin
				ax_q <= xa_q; ay_q <= ya_q; px_q <= xa_q; py_q <= ya_q;
			end
			ST_LSETUP: begin
				ldx_q <= (l2x >= l1x) ? l2x - l1x : l1x - l2x;
				ldy_q <= (l2y >= l1y) ? l2y - l1y : l1y - l2y;
				dist_q <= ((l2x >= l1x ? l2x - l1x : l1x - l2x) >
					(l2y >= l1y ? l2y - l1y : l1y - l2y)) ?
					(l2x >= l1x ? l2x - l1x : l1x - l2x) :
					(l2y >= l1y ? l2y - l1y : l1y - l2y);
				sxn_q <= l2x < l1x; syn_q <= l2y < l1y;
				cx_q <= {1'b0, l1x}; cy_q <= {1'b0, l1y};
				px_q <= l1x; py_q <= l1y;
				ex_q <= '0; ey_q <= '0; t_q <= '0;
			end
			ST_WB: begin
				if (area_mode_q) begin
					if (ay_q + 8'd1 == yb_q) begin
						ay_q <= ya_q; ax_q <= ax_q + 8'd1;
						py_q <= ya_q; px_q <= ax_q + 8'd1;
					end else begin
						ay_q <= ay_q + 8'd1; py_q <= ay_q + 8'd1;
					end
				end else if (op_q == OP_LINE || op_q == OP_RECT) begin
					t_q <= t_q + 9'd1;
					if (last_pt) seg_q <= seg_q + 2'd1;
					if (ex_n > {1'b0, dist_q}) begin
						ex_q <= ex_n - {1'b0, dist_q};
						cx_q <= sxn_q ? cx_q - 9'd1 : cx_q + 9'd1;
						px_q <= sxn_q ? cx_q[7:0] - 8'd1 : cx_q[7:0] + 8'd1;
					end else ex_q <= ex_n;
					if (ey_n > {1'b0, dist_q}) begin
						ey_q <= ey_n - {1'b0, dist_q};
						cy_q <= syn_q ? cy_q - 9'd1 : cy_q + 9'd1;
						py_q <= syn_q ? cy_q[7:0] - 8'd1 : cy_q[7:0] + 8'd1;
					end else ey_q <= ey_n;
				end
			end
			ST_DRAIN: rd_out_q <= rd_ok ? rdata_q : 8'd0;
			default: begin end
		endcase
	end

	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("accept while result pending");
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !s_tready) else $error("accept during clear");
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the monochrome framebuffer draw engine
// ----------------------------------------------------------------------------
// drives draw and read commands over the slave stream with random gaps, keeps
// a local shadow of the framebuffer that replays every accepted command, and
// compares each completion item against the shadow; read byte items check the
// store contents, so drawing commands are observed through later reads
// ----------------------------------------------------------------------------
module tb;
	import mfde_pkg::*;

	localparam int COLS      = 128;
	localparam int PGS       = 8;
	localparam int ROWS      = PGS * 8;
	localparam int LIMIT     = 10000000;
	localparam int IDLE_PCT  = 29;

	typedef struct packed {
		logic [7:0] read_data;
		op_t        op;
	} done_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // op, start_x, start_y, end_x, end_y
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // read_data, done_op

	logic [7:0] shadow_fb [PGS*COLS];
	done_t      pending_done [$];
	int         cycles;
	int         errors;
	int         sent;
	int         received;
	int         reads_sent;
	int         hold_len;
	bit         idle_on;

	mono_framebuffer_draw_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void put_pixel(int x, int y, bit on);
		int idx;
		if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return;
		idx = (y / 8) * COLS + x;
		if (on) shadow_fb[idx][y % 8] = 1'b1;
		else shadow_fb[idx][y % 8] = 1'b0;
	endfunction

	function automatic void shade_area(int x0, int y0, int x1, int y1, bit on);
		for (int x = x0; x < x1; x++)
			for (int y = y0; y < y1; y++)
				put_pixel(x, y, on);
	endfunction

	function automatic void trace_line(int x1, int y1, int x2, int y2);
		int dx, dy, sx, sy, span, ex, ey, cx, cy;
		dx = x2 - x1;
		dy = y2 - y1;
		sx = 0;
		sy = 0;
		ex = 0;
		ey = 0;
		cx = x1;
		cy = y1;
		if (dx > 0) sx = 1;
		else if (dx < 0) begin
			sx = -1;
			dx = -dx;
		end
		if (dy > 0) sy = 1;
		else if (dy < 0) begin
			sy = -1;
			dy = -dy;
		end
		span = (dx > dy) ? dx : dy;
		for (int t = 0; t <= span + 1; t++) begin
			put_pixel(cx, cy, 1'b1);
			ex += dx;
			ey += dy;
			if (ex > span) begin
				ex -= span;
				cx += sx;
			end
			if (ey > span) begin
				ey -= span;
				cy += sy;
			end
		end
	endfunction

	function automatic done_t apply_command(op_t op, int xa, int ya, int xb, int yb);
		done_t r;
		r.op = op;
		r.read_data = 8'd0;
		case (op)
			OP_SET:   put_pixel(xa, ya, 1'b1);
			OP_CLR:   put_pixel(xa, ya, 1'b0);
			OP_FILL:  shade_area(xa, ya, xb, yb, 1'b1);
			OP_ERASE: shade_area(xa, ya, xb, yb, 1'b0);
			OP_LINE:  trace_line(xa, ya, xb, yb);
			OP_RECT: begin
				trace_line(xa, ya, xb, ya);
				trace_line(xa, ya, xa, yb);
				trace_line(xa, yb, xb, yb);
				trace_line(xb, ya, xb, yb);
			end
			OP_WIPE: begin
				for (int i = 0; i < PGS * COLS; i++) shadow_fb[i] = 8'd0;
			end
			default: begin
				if (xa < COLS && ya < PGS) r.read_data = shadow_fb[ya * COLS + xa];
			end
		endcase
		return r;
	endfunction

	function automatic bit idle_now();
		return idle_on && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	task automatic send_cmd(op_t op, int xa, int ya, int xb, int yb);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, yb[7:0], xb[7:0], ya[7:0], xa[7:0], op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_done.push_back(apply_command(op, xa, ya, xb, yb));
		sent++;
		if (op == OP_READ) reads_sent++;
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		while (pending_done.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			received++;
			if (pending_done.size() == 0) begin
				errors++;
				$display("%0t: unexpected item read_data=%02h done_op=%0d",
					$time, m_tdata[7:0], m_tdata[10:8]);
			end else begin
				done_t e;
				e = pending_done.pop_front();
				if (m_tdata[7:0] !== e.read_data) begin
					errors++;
					$display("%0t: read_data expected %02h actual %02h (op %0d)",
						$time, e.read_data, m_tdata[7:0], e.op);
				end
				if (m_tdata[10:8] !== e.op) begin
					errors++;
					$display("%0t: done_op expected %0d actual %0d",
						$time, e.op, m_tdata[10:8]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_len > 0) begin
			m_tready <= 1'b0;
			hold_len <= hold_len - 1;
		end else begin
			m_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int pick_coord();
		if ($urandom_range(0, 99) < 80) return $urandom_range(0, 135);
		return $urandom_range(0, 255);
	endfunction

	task automatic read_sweep(int n);
		for (int i = 0; i < n; i++)
			send_cmd(OP_READ, $urandom_range(0, COLS - 1), $urandom_range(0, PGS - 1),
				$urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic test_directed();
		send_cmd(OP_SET, 0, 0, 255, 255);
		send_cmd(OP_SET, 127, 63, 0, 0);
		send_cmd(OP_SET, 128, 0, 0, 0);
		send_cmd(OP_SET, 0, 64, 0, 0);
		send_cmd(OP_SET, 255, 255, 0, 0);
		send_cmd(OP_READ, 0, 0, 0, 0);
		send_cmd(OP_READ, 127, 7, 0, 0);
		send_cmd(OP_CLR, 0, 0, 0, 0);
		send_cmd(OP_READ, 0, 0, 255, 255);
		send_cmd(OP_FILL, 0, 0, COLS, ROWS);
		send_cmd(OP_READ, 64, 3, 0, 0);
		send_cmd(OP_ERASE, 10, 5, 10, 40);
		send_cmd(OP_ERASE, 30, 20, 20, 30);
		send_cmd(OP_ERASE, 120, 60, 255, 255);
		send_cmd(OP_READ, 127, 7, 0, 0);
		send_cmd(OP_WIPE, 5, 5, 5, 5);
		send_cmd(OP_LINE, 40, 20, 40, 20);
		send_cmd(OP_LINE, 100, 50, 3, 10);
		send_cmd(OP_LINE, 200, 200, 0, 0);
		send_cmd(OP_LINE, 5, 0, 9, 63);
		send_cmd(OP_RECT, 120, 55, 140, 70);
		send_cmd(OP_READ, 128, 0, 0, 0);
		send_cmd(OP_READ, 0, 8, 0, 0);
		send_cmd(OP_READ, 255, 255, 0, 0);
		read_sweep(8);
		stop_sending();
	endtask

	task automatic random_cmd();
		int k, xa, ya, xb, yb;
		k  = $urandom_range(0, 99);
		xa = pick_coord();
		ya = pick_coord();
		if (k < 35) begin
			send_cmd(OP_READ, $urandom_range(0, 99) < 90 ? $urandom_range(0, COLS - 1)
				: $urandom_range(0, 255), $urandom_range(0, 99) < 90
				? $urandom_range(0, PGS - 1) : $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
		end else if (k < 50) begin
			send_cmd($urandom_range(0, 1) ? OP_SET : OP_CLR, xa, ya,
				$urandom_range(0, 255), $urandom_range(0, 255));
		end else if (k < 70) begin
			xb = xa + $urandom_range(0, 14) - 2;
			yb = ya + $urandom_range(0, 14) - 2;
			if (xb < 0) xb = 0;
			if (yb < 0) yb = 0;
			if (xb > 255) xb = 255;
			if (yb > 255) yb = 255;
			send_cmd($urandom_range(0, 1) ? OP_FILL : OP_ERASE, xa, ya, xb, yb);
		end else if (k < 87) begin
			send_cmd(OP_LINE, xa, ya, pick_coord(), pick_coord());
		end else if (k < 98) begin
			send_cmd(OP_RECT, xa, ya, pick_coord(), pick_coord());
		end else begin
			send_cmd(OP_WIPE, xa, ya, $urandom_range(0, 255), $urandom_range(0, 255));
		end
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			idle_on = !(i >= n / 3 && i < n / 2);
			random_cmd();
		end
		idle_on = 1'b1;
		stop_sending();
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_len <= 600;
		for (int i = 0; i < 12; i++) random_cmd();
		read_sweep(10);
		stop_sending();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		cycles   = 0;
		errors   = 0;
		sent     = 0;
		received = 0;
		reads_sent = 0;
		hold_len = 0;
		idle_on  = 1'b1;
		for (int i = 0; i < PGS * COLS; i++) shadow_fb[i] = 8'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(360);
		test_backpressure();
		repeat (50) @(posedge clk);
		$display("covered %0d commands (%0d read backs), %0d completions checked",
			sent, reads_sent, received);
		$display("directed edge cases, random draws with gaps, long output stall");
		if (errors == 0 && pending_done.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
